### rtl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Shared widths, constants and controller/datapath interface types for the
// sample interval statistics block.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int SCALE_W   = 32;
    localparam int COUNT_W   = 32;
    localparam int STAT_W    = 48;
    localparam int SUM_W     = 64;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_mean;
        logic freq_set;
        logic update;
        logic emit;
    } sis_cmd_t;

    typedef struct packed {
        logic has_interval;
        logic step_zero;
        logic count_zero;
        logic div_busy;
        logic out_free;
    } sis_status_t;

endpackage

### rtl/sis_divider.sv
// ----------------------------------------------------------------------------
// sis_divider
// Unsigned restoring divider, one quotient bit per cycle. The dividend is
// loaded left aligned; after the requested number of iterations the quotient
// register holds the full quotient.
// ----------------------------------------------------------------------------
module sis_divider
    import sis_pkg::*;
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32,
    parameter int CNT_W = 7
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] iters,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   partial;
    logic [DEN_W:0]   trial;
    logic             fits;

    always_comb
    begin
        partial = {rem_reg, quo_reg[NUM_W-1]};
        trial   = partial - {1'b0, den_reg};
        fits    = (partial >= {1'b0, den_reg});
        if (start)
        begin
            cnt_next = iters;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
        rem_next = fits ? trial[DEN_W-1:0] : partial[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

### rtl/sis_datapath.sv
// ----------------------------------------------------------------------------
// sis_datapath
// Statistics registers, step computation, shared divider operands, frequency
// saturation and the output register.
// ----------------------------------------------------------------------------
module sis_datapath
    import sis_pkg::*;
#(
    parameter int TIME_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sis_cmd_t                 cmd,
    output sis_status_t              status,
    input  logic                     cfg_wr_en,
    input  logic [SCALE_W-1:0]       cfg_wr_data,
    input  logic [TIME_WIDTH-1:0]    sample_time,
    input  logic                     record_start,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [TIME_WIDTH-1:0]    first_stamp,
    output logic [TIME_WIDTH-1:0]    last_stamp,
    output logic [TIME_WIDTH-1:0]    record_span,
    output logic signed [STAT_W-1:0] freq_peak,
    output logic signed [STAT_W-1:0] freq_trough,
    output logic signed [STAT_W-1:0] freq_mean,
    output logic [COUNT_W-1:0]       intervals_seen,
    output logic                     frequency_valid,
    output logic                     zero_interval
);

    localparam int DEN_W      = (TIME_WIDTH > COUNT_W) ? TIME_WIDTH : COUNT_W;
    localparam int DIFF_W     = TIME_WIDTH + 1;
    localparam int FREQ_ITERS = SCALE_W + FRAC_BITS;

    localparam logic signed [STAT_W-1:0] F48_MAX = {1'b0, {(STAT_W-1){1'b1}}};
    localparam logic signed [STAT_W-1:0] F48_MIN = {1'b1, {(STAT_W-1){1'b0}}};
    localparam logic [DIV_NUM_W-1:0] Q_POS_LIM =
        {{(DIV_NUM_W-STAT_W+1){1'b0}}, {(STAT_W-1){1'b1}}};
    localparam logic [DIV_NUM_W-1:0] Q_NEG_LIM =
        {{(DIV_NUM_W-STAT_W){1'b0}}, 1'b1, {(STAT_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    function automatic logic signed [STAT_W-1:0] sat_quot(
        input logic [DIV_NUM_W-1:0] q,
        input logic                 neg
    );
        logic signed [STAT_W-1:0] r;
        if (!neg)
        begin
            r = (q > Q_POS_LIM) ? F48_MAX : q[STAT_W-1:0];
        end
        else
        begin
            r = (q > Q_NEG_LIM) ? F48_MIN : (~q[STAT_W-1:0] + STAT_W'(1));
        end
        return r;
    endfunction

    // configuration and statistics
    logic [SCALE_W-1:0]       rate_scale_reg;
    logic [TIME_WIDTH-1:0]    earliest_reg;
    logic [TIME_WIDTH-1:0]    latest_reg;
    logic [TIME_WIDTH-1:0]    previous_reg;
    logic                     have_prev_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic signed [STAT_W-1:0] high_reg;
    logic signed [STAT_W-1:0] low_reg;

    // per-item working registers
    logic                     interval_reg;
    logic                     zero_reg;
    logic                     step_neg_reg;
    logic [TIME_WIDTH-1:0]    step_mag_reg;
    logic signed [STAT_W-1:0] freq_reg;
    logic                     mean_neg_reg;

    // output register
    logic                     out_valid_reg;
    logic [TIME_WIDTH-1:0]    out_start_reg;
    logic [TIME_WIDTH-1:0]    out_finish_reg;
    logic [TIME_WIDTH-1:0]    out_duration_reg;
    logic signed [STAT_W-1:0] out_max_reg;
    logic signed [STAT_W-1:0] out_min_reg;
    logic signed [STAT_W-1:0] out_avg_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic                     out_fvalid_reg;
    logic                     out_zero_reg;

    logic                     have_eff;
    logic [DIFF_W-1:0]        diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic [TIME_WIDTH-1:0]    earliest_next;
    logic [TIME_WIDTH-1:0]    latest_next;
    logic [SUM_W:0]           sum_ext;
    logic [SUM_W-1:0]         sum_next;
    logic [SUM_W-1:0]         sum_mag;
    logic [DIV_NUM_W-1:0]     div_dividend;
    logic [DEN_W-1:0]         div_divisor;
    logic [DIV_CNT_W-1:0]     div_iters;
    logic                     div_busy;
    logic [DIV_NUM_W-1:0]     div_quot;
    logic                     out_free;
    logic                     have_count;

    always_comb
    begin
        have_eff = have_prev_reg & ~record_start;
        diff     = {1'b0, sample_time} - {1'b0, previous_reg};
        diff_abs = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
        if (record_start)
        begin
            earliest_next = sample_time;
            latest_next   = sample_time;
        end
        else
        begin
            earliest_next = (sample_time < earliest_reg) ? sample_time : earliest_reg;
            latest_next   = (sample_time > latest_reg) ? sample_time : latest_reg;
        end

        sum_ext = {sum_reg[SUM_W-1], sum_reg}
                + {{(SUM_W-STAT_W+1){freq_reg[STAT_W-1]}}, freq_reg};
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
        begin
            sum_next = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = sum_ext[SUM_W-1:0];
        end
        sum_mag = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;

        if (cmd.div_mean)
        begin
            div_dividend = sum_mag;
            div_divisor  = DEN_W'(count_reg);
            div_iters    = DIV_CNT_W'(DIV_NUM_W);
        end
        else
        begin
            div_dividend = {rate_scale_reg, {(DIV_NUM_W-SCALE_W){1'b0}}};
            div_divisor  = DEN_W'(step_mag_reg);
            div_iters    = DIV_CNT_W'(FREQ_ITERS);
        end

        out_free   = ~out_valid_reg | result_ready;
        have_count = (count_reg != '0);
    end

    sis_divider #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DEN_W),
        .CNT_W (DIV_CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .iters    (div_iters),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_scale_reg <= SCALE_W'(1);
            earliest_reg   <= '1;
            latest_reg     <= '0;
            previous_reg   <= '0;
            have_prev_reg  <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            high_reg       <= F48_MIN;
            low_reg        <= F48_MAX;
            interval_reg   <= 1'b0;
            zero_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rate_scale_reg <= cfg_wr_data;
            end
            if (cmd.capture)
            begin
                earliest_reg  <= earliest_next;
                latest_reg    <= latest_next;
                previous_reg  <= sample_time;
                have_prev_reg <= 1'b1;
                interval_reg  <= have_eff;
                zero_reg      <= (diff == '0);
                if (record_start)
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                    high_reg  <= F48_MIN;
                    low_reg   <= F48_MAX;
                end
            end
            if (cmd.update)
            begin
                if (freq_reg > high_reg)
                begin
                    high_reg <= freq_reg;
                end
                if (freq_reg < low_reg)
                begin
                    low_reg <= freq_reg;
                end
                if (count_reg != '1)
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                    sum_reg   <= sum_next;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            step_neg_reg <= diff[DIFF_W-1];
            step_mag_reg <= diff_abs[TIME_WIDTH-1:0];
        end
        if (cmd.freq_set)
        begin
            freq_reg <= zero_reg ? F48_MAX : sat_quot(div_quot, step_neg_reg);
        end
        if (cmd.div_start && cmd.div_mean)
        begin
            mean_neg_reg <= sum_reg[SUM_W-1];
        end
        if (cmd.emit)
        begin
            out_start_reg    <= earliest_reg;
            out_finish_reg   <= latest_reg;
            out_duration_reg <= latest_reg - earliest_reg;
            out_count_reg    <= count_reg;
            out_fvalid_reg   <= have_count;
            out_zero_reg     <= interval_reg & zero_reg;
            out_max_reg      <= have_count ? high_reg : '0;
            out_min_reg      <= have_count ? low_reg : '0;
            out_avg_reg      <= have_count ? sat_quot(div_quot, mean_neg_reg) : '0;
        end
    end

    assign status.has_interval = interval_reg;
    assign status.step_zero    = zero_reg;
    assign status.count_zero   = ~have_count;
    assign status.div_busy     = div_busy;
    assign status.out_free     = out_free;

    assign result_valid    = out_valid_reg;
    assign first_stamp     = out_start_reg;
    assign last_stamp      = out_finish_reg;
    assign record_span     = out_duration_reg;
    assign freq_peak       = out_max_reg;
    assign freq_trough     = out_min_reg;
    assign freq_mean       = out_avg_reg;
    assign intervals_seen  = out_count_reg;
    assign frequency_valid = out_fvalid_reg;
    assign zero_interval   = out_zero_reg;

endmodule

### rtl/sis_controller.sv
// ----------------------------------------------------------------------------
// sis_controller
// Sequencer for one sample: capture, frequency division, statistics update,
// mean division and hand-off to the output register.
// ----------------------------------------------------------------------------
module sis_controller
    import sis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  sis_status_t status,
    output sis_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FREQ_DIV,
        S_FREQ_SET,
        S_UPDATE,
        S_MEAN_START,
        S_MEAN_DIV,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid && ready_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.has_interval && !status.step_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_FREQ_DIV;
                end
                else if (status.has_interval)
                begin
                    state_next = S_FREQ_SET;
                end
                else
                begin
                    state_next = S_MEAN_START;
                end
            end
            S_FREQ_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_FREQ_SET;
                end
            end
            S_FREQ_SET:
            begin
                cmd.freq_set = 1'b1;
                state_next   = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_MEAN_START;
            end
            S_MEAN_START:
            begin
                if (status.count_zero)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_mean  = 1'b1;
                    state_next    = S_MEAN_DIV;
                end
            end
            S_MEAN_DIV:
            begin
                cmd.div_mean = 1'b1;
                if (!status.div_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.div_mean = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign sample_ready = ready_reg;

endmodule

### rtl/sample_interval_statistics.sv
// ----------------------------------------------------------------------------
// sample_interval_statistics
// Running timestamp statistics over one record: earliest/latest time,
// duration, interval count and min/max/mean instantaneous frequency.
// ----------------------------------------------------------------------------
// One sample beat is processed at a time. For a sample with an interval, both
// the frequency quotient and the mean go through one shared bit-serial
// divider, one quotient bit per cycle. A zero time step skips the frequency
// division, and a sample with no interval in its record skips both. The next
// sample can be accepted on the cycle after a result is handed to the output
// register, even while that result is still waiting on result_ready.
// rate_scale is written through cfg_wr_en/cfg_wr_data, and only while the
// block is idle: the user must keep to this, the block does not enforce it.
module sample_interval_statistics
    import sis_pkg::*;
#(
    parameter int TIME_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [SCALE_W-1:0]       cfg_wr_data,
    input  logic                     sample_valid,
    output logic                     sample_ready,
    input  logic [TIME_WIDTH-1:0]    sample_time,
    input  logic                     record_start,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [TIME_WIDTH-1:0]    first_stamp,
    output logic [TIME_WIDTH-1:0]    last_stamp,
    output logic [TIME_WIDTH-1:0]    record_span,
    output logic signed [STAT_W-1:0] freq_peak,
    output logic signed [STAT_W-1:0] freq_trough,
    output logic signed [STAT_W-1:0] freq_mean,
    output logic [COUNT_W-1:0]       intervals_seen,
    output logic                     frequency_valid,
    output logic                     zero_interval
);

    sis_cmd_t    cmd;
    sis_status_t status;

    sis_controller u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    sis_datapath #(
        .TIME_WIDTH (TIME_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .sample_time     (sample_time),
        .record_start    (record_start),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .first_stamp     (first_stamp),
        .last_stamp      (last_stamp),
        .record_span     (record_span),
        .freq_peak       (freq_peak),
        .freq_trough     (freq_trough),
        .freq_mean       (freq_mean),
        .intervals_seen  (intervals_seen),
        .frequency_valid (frequency_valid),
        .zero_interval   (zero_interval)
    );

endmodule
